### hdl/lpfr_pkg.sv
package lpfr_pkg;

	localparam int FRAMES     = 16;
	localparam int PAGE_BITS  = 20;
	localparam int SLOT_BITS  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int RANK_BITS  = SLOT_BITS;
	localparam int COUNT_BITS = 5;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic                  flush;
		logic                  load;
		logic [PAGE_BITS-1:0]  probe;
		logic [COUNT_BITS-1:0] active_n;
		logic [RANK_BITS-1:0]  last_rank;
		logic                  pick;
		logic                  hit_any;
		logic                  empty_any;
		logic                  update;
		logic                  is_hit;
		logic [RANK_BITS-1:0]  limit;
		logic [PAGE_BITS-1:0]  page;
	} cmd_t;

	// passed from one cell to the next
	typedef struct packed {
		logic                 match_seen;
		logic                 empty_seen;
		logic [RANK_BITS-1:0] sel_rank;
		logic [SLOT_BITS-1:0] sel_slot;
		logic [PAGE_BITS-1:0] sel_page;
	} link_t;

endpackage

### hdl/lpfr_cell.sv
module lpfr_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [lpfr_pkg::SLOT_BITS-1:0] cell_idx,
	input  lpfr_pkg::cmd_t                 cmd,
	input  lpfr_pkg::link_t                link_in,
	output lpfr_pkg::link_t                link_out
);

	logic [lpfr_pkg::PAGE_BITS-1:0] page_q;
	logic                           used_q;
	logic [lpfr_pkg::RANK_BITS-1:0] rank_q;
	logic                           match_q;
	logic                           empty_q;
	logic                           oldest_q;
	logic                           sel_q;
	logic                           active;
	logic                           sel_d;

	assign active = {{(lpfr_pkg::COUNT_BITS-lpfr_pkg::SLOT_BITS){1'b0}}, cell_idx}
	                < cmd.active_n;

	// first match / first empty claimed along the chain, else the oldest frame
	always_comb begin
		if (cmd.hit_any) begin
			sel_d = match_q & ~link_in.match_seen;
		end else if (cmd.empty_any) begin
			sel_d = empty_q & ~link_in.empty_seen;
		end else begin
			sel_d = oldest_q;
		end
	end

	assign link_out.match_seen = link_in.match_seen | match_q;
	assign link_out.empty_seen = link_in.empty_seen | empty_q;
	assign link_out.sel_rank   = link_in.sel_rank | (sel_q ? rank_q : '0);
	assign link_out.sel_slot   = link_in.sel_slot | (sel_q ? cell_idx : '0);
	assign link_out.sel_page   = link_in.sel_page | (sel_q ? page_q : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= 1'b0;
			rank_q   <= '0;
			match_q  <= 1'b0;
			empty_q  <= 1'b0;
			oldest_q <= 1'b0;
			sel_q    <= 1'b0;
		end else if (cmd.flush) begin
			used_q <= 1'b0;
			rank_q <= '0;
		end else begin
			if (cmd.load) begin
				match_q  <= active & used_q & (page_q == cmd.probe);
				empty_q  <= active & ~used_q;
				oldest_q <= active & used_q & (rank_q == cmd.last_rank);
			end
			if (cmd.pick) begin
				sel_q <= sel_d;
			end
			if (cmd.update) begin
				if (sel_q) begin
					used_q <= 1'b1;
					rank_q <= '0;
				end else if (used_q && (!cmd.is_hit || rank_q < cmd.limit)) begin
					rank_q <= rank_q + 1'b1;
				end
			end
		end
	end

	// page store has no reset, it is only read for used frames
	always_ff @(posedge clk) begin
		if (cmd.update && sel_q && !cmd.is_hit) begin
			page_q <= cmd.page;
		end
	end

endmodule

### hdl/lru_page_frame_replacement.sv
// lru page frame replacement, fully associative, one cell per frame
//
// input channel: in_valid / in_ready, one page_number per word
// output channel: out_valid / out_ready, one result word per reference
//   (is_hit, slot_valid, frame_slot, evict_valid, evicted_page)
// config: frame_count is written when frame_count_we is high; any write
//   flushes all frames, counts above the frame total saturate
//
// each reference goes through accept (every cell compares its page),
// select (priority claim ripples along the cell chain), gather (the chosen
// cell's rank, slot and page ripple out) and update (ranks age, result
// loaded). the next reference is accepted in the cycle after the update
//
// the result sits in an output register; a new reference is accepted while
// it waits, but its update step holds until the old word is taken
//
// reset empties all frames, clears ranks, sets frame_count to 16 and drops
// out_valid
module lru_page_frame_replacement (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            frame_count_we,
	input  logic [lpfr_pkg::COUNT_BITS-1:0] frame_count,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [lpfr_pkg::PAGE_BITS-1:0]  page_number,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            is_hit,
	output logic                            slot_valid,
	output logic [lpfr_pkg::SLOT_BITS-1:0]  frame_slot,
	output logic                            evict_valid,
	output logic [lpfr_pkg::PAGE_BITS-1:0]  evicted_page
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SEL  = 4'b0010,
		ST_GATH = 4'b0100,
		ST_UPD  = 4'b1000
	} state_t;

	localparam logic [lpfr_pkg::COUNT_BITS-1:0] FrameMax =
		lpfr_pkg::COUNT_BITS'(lpfr_pkg::FRAMES);

	state_t                            state_q;
	logic [lpfr_pkg::COUNT_BITS-1:0]   count_q;
	logic [lpfr_pkg::PAGE_BITS-1:0]    page_q;
	logic                              hit_q;
	logic                              empty_q;
	logic [lpfr_pkg::RANK_BITS-1:0]    limit_q;
	logic [lpfr_pkg::SLOT_BITS-1:0]    slot_q;
	logic [lpfr_pkg::PAGE_BITS-1:0]    victim_q;
	logic                              out_valid_q;
	logic                              is_hit_q;
	logic                              slot_valid_q;
	logic [lpfr_pkg::SLOT_BITS-1:0]    frame_slot_q;
	logic                              evict_valid_q;
	logic [lpfr_pkg::PAGE_BITS-1:0]    evicted_page_q;

	logic [lpfr_pkg::COUNT_BITS-1:0]   active_n;
	logic                              in_fire;
	logic                              done;
	logic                              placed;
	logic                              evict;
	lpfr_pkg::cmd_t                    cmd;
	lpfr_pkg::link_t                   chain [lpfr_pkg::FRAMES+1];

	// saturate the frame count to the number of cells
	assign active_n = (count_q > FrameMax) ? FrameMax : count_q;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid & in_ready;
	// update only once the output register is free
	assign done     = (state_q == ST_UPD) & (~out_valid_q | out_ready);

	assign placed = (active_n != '0);
	assign evict  = placed & ~hit_q & ~empty_q;

	always_comb begin
		cmd           = '0;
		cmd.flush     = frame_count_we;
		cmd.load      = in_fire;
		cmd.probe     = page_number;
		cmd.active_n  = active_n;
		cmd.last_rank = lpfr_pkg::RANK_BITS'(active_n - 1'b1);
		cmd.pick      = (state_q == ST_SEL);
		cmd.hit_any   = chain[lpfr_pkg::FRAMES].match_seen;
		cmd.empty_any = chain[lpfr_pkg::FRAMES].empty_seen;
		cmd.update    = done;
		cmd.is_hit    = hit_q;
		cmd.limit     = limit_q;
		cmd.page      = page_q;
	end

	assign chain[0] = '0;

	for (genvar g = 0; g < lpfr_pkg::FRAMES; g++) begin : g_cell
		lpfr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (lpfr_pkg::SLOT_BITS'(g)),
			.cmd      (cmd),
			.link_in  (chain[g]),
			.link_out (chain[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= FrameMax;
			out_valid_q <= 1'b0;
		end else begin
			if (frame_count_we) begin
				count_q <= frame_count;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SEL;
					end
				end
				ST_SEL:  state_q <= ST_GATH;
				ST_GATH: state_q <= ST_UPD;
				ST_UPD: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			page_q <= page_number;
		end
		if (state_q == ST_SEL) begin
			hit_q   <= chain[lpfr_pkg::FRAMES].match_seen;
			empty_q <= chain[lpfr_pkg::FRAMES].empty_seen;
		end
		if (state_q == ST_GATH) begin
			limit_q  <= chain[lpfr_pkg::FRAMES].sel_rank;
			slot_q   <= chain[lpfr_pkg::FRAMES].sel_slot;
			victim_q <= chain[lpfr_pkg::FRAMES].sel_page;
		end
		if (done) begin
			is_hit_q       <= hit_q;
			slot_valid_q   <= placed;
			frame_slot_q   <= placed ? slot_q : '0;
			evict_valid_q  <= evict;
			evicted_page_q <= evict ? victim_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_hit       = is_hit_q;
	assign slot_valid   = slot_valid_q;
	assign frame_slot   = frame_slot_q;
	assign evict_valid  = evict_valid_q;
	assign evicted_page = evicted_page_q;

endmodule

### bench/lru_page_frame_replacement_test.sv
module lru_page_frame_replacement_test;
	timeunit 1ns;
	timeprecision 1ps;

	// settle margin after the last owed word has come back
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;
	// far beyond the slowest correct run with heavy stalls
	localparam longint RUN_LIMIT_NS = 5_000_000;

	// one expected result word
	typedef struct {
		logic                           hit;
		logic                           placed;
		logic [lpfr_pkg::SLOT_BITS-1:0] slot;
		logic                           evicted;
		logic [lpfr_pkg::PAGE_BITS-1:0] old_page;
	} lru_result_t;

	logic                            clk            = 1'b0;
	logic                            arst_n         = 1'b0;
	logic                            frame_count_we = 1'b0;
	logic [lpfr_pkg::COUNT_BITS-1:0] frame_count    = '0;
	logic                            in_valid       = 1'b0;
	logic                            in_ready;
	logic [lpfr_pkg::PAGE_BITS-1:0]  page_number    = '0;
	logic                            out_valid;
	logic                            out_ready      = 1'b0;
	logic                            is_hit;
	logic                            slot_valid;
	logic [lpfr_pkg::SLOT_BITS-1:0]  frame_slot;
	logic                            evict_valid;
	logic [lpfr_pkg::PAGE_BITS-1:0]  evicted_page;

	// percent of cycles each side holds off
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count   = 0;

	// shadow copy of the frame store
	int                             shadow_count = 16;
	logic [lpfr_pkg::PAGE_BITS-1:0] held_page [lpfr_pkg::FRAMES];
	bit                             frame_busy[lpfr_pkg::FRAMES];
	int                             age_rank  [lpfr_pkg::FRAMES];

	// result words still owed by the block, oldest first
	lru_result_t expected_q[$];

	lru_page_frame_replacement DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.frame_count_we(frame_count_we),
		.frame_count   (frame_count),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.page_number   (page_number),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.is_hit        (is_hit),
		.slot_valid    (slot_valid),
		.frame_slot    (frame_slot),
		.evict_valid   (evict_valid),
		.evicted_page  (evicted_page)
	);

	always #5 clk = ~clk;

	// empty every shadow frame, as any count write does in the block
	function automatic void flush_shadow();
		for (int j = 0; j < lpfr_pkg::FRAMES; j++) begin
			held_page[j]  = '0;
			frame_busy[j] = 1'b0;
			age_rank[j]   = 0;
		end
	endfunction

	// look up one page in the shadow store, update it and return the word the block owes
	function automatic lru_result_t predict_reference(
			input logic [lpfr_pkg::PAGE_BITS-1:0] page);
		lru_result_t r;
		int          n;
		int          victim;
		int          worst;
		int          limit;
		bit          found;
		r = '{hit: 1'b0, placed: 1'b0, slot: '0, evicted: 1'b0, old_page: '0};
		// counts above the frame total saturate
		n = (shadow_count > lpfr_pkg::FRAMES) ? lpfr_pkg::FRAMES : shadow_count;
		found = 1'b0;
		victim = 0;
		// first matching used frame wins
		for (int j = 0; j < n; j++) begin
			if (!found && frame_busy[j] && held_page[j] == page) begin
				found = 1'b1;
				victim = j;
			end
		end
		// zero active frames: plain fault, nothing changes
		if (n == 0)
			return r;
		if (found) begin
			r.hit = 1'b1;
			// only frames more recent than the hit one age
			limit = age_rank[victim];
		end else begin
			limit = 255;
			victim = -1;
			for (int j = 0; j < n; j++) begin
				if (victim < 0 && !frame_busy[j])
					victim = j;
			end
			if (victim >= 0) begin
				frame_busy[victim] = 1'b1;
			end else begin
				// all full: oldest rank goes, ties to the highest index
				worst = 0;
				victim = 0;
				for (int j = 0; j < n; j++) begin
					if (frame_busy[j] && age_rank[j] >= worst) begin
						worst = age_rank[j];
						victim = j;
					end
				end
				r.evicted  = 1'b1;
				r.old_page = held_page[victim];
			end
			held_page[victim] = page;
		end
		for (int j = 0; j < n; j++) begin
			if (frame_busy[j] && j != victim && age_rank[j] < limit)
				age_rank[j] = age_rank[j] + 1;
		end
		age_rank[victim] = 0;
		r.placed = 1'b1;
		r.slot   = lpfr_pkg::SLOT_BITS'(victim);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string field, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
	endtask

	// receiver side: random stall on out_ready
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin : result_checker
		lru_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("result word with nothing expected");
			end else begin
				want = expected_q.pop_front();
				check_field("is_hit", is_hit, want.hit);
				check_field("slot_valid", slot_valid, want.placed);
				check_field("frame_slot", frame_slot, want.slot);
				check_field("evict_valid", evict_valid, want.evicted);
				check_field("evicted_page", evicted_page, want.old_page);
			end
		end
	end

	// offer one page reference, with a random hold-off first
	task automatic send_page(input logic [lpfr_pkg::PAGE_BITS-1:0] page);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		page_number <= page;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// word taken at this edge, the shadow store moves on with it
		expected_q.insert(expected_q.size(), predict_reference(page));
	endtask

	// stop sending and let every owed word come back, then let the block settle
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// frame count write, only ever with the block idle
	task automatic set_frame_count(input logic [lpfr_pkg::COUNT_BITS-1:0] count);
		wait_for_results();
		frame_count_we <= 1'b1;
		frame_count    <= count;
		@(posedge clk);
		frame_count_we <= 1'b0;
		shadow_count = count;
		flush_shadow();
	endtask

	// count of 16 straight out of reset, extreme page numbers
	task automatic test_reset_default();
		send_page(20'h00000);
		send_page(20'hFFFFF);
		send_page(20'h00000);
		send_page(20'hFFFFF);
	endtask

	// three frames: fill, hit, two evictions, then a rewrite of the same count flushes
	task automatic test_small_lru();
		set_frame_count(5'd3);
		send_page(20'h00001);
		send_page(20'hFFFFF);
		send_page(20'h80000);
		send_page(20'h00001);
		send_page(20'h12345);
		send_page(20'hFFFFF);
		set_frame_count(5'd3);
		send_page(20'h00001);
	endtask

	// one frame: after the first fill, every new page evicts the last one
	task automatic test_single_frame();
		set_frame_count(5'd1);
		send_page(20'h55555);
		send_page(20'h55555);
		send_page(20'hAAAAA);
	endtask

	// zero frames: everything faults and nothing is stored
	task automatic test_zero_frames();
		set_frame_count(5'd0);
		send_page(20'hFFFFF);
		send_page(20'hFFFFF);
	endtask

	// largest count saturates to the frame total
	task automatic test_saturated_count();
		set_frame_count(5'd31);
		send_page(20'h0000F);
		send_page(20'hF0000);
		send_page(20'h0000F);
	endtask

	// sender goes quiet in mid-stream until the block has nothing left to return
	task automatic test_pause_until_drained();
		logic [lpfr_pkg::PAGE_BITS-1:0] pool[4];
		set_frame_count(5'd4);
		foreach (pool[k])
			pool[k] = lpfr_pkg::PAGE_BITS'($urandom);
		repeat (8) send_page(pool[$urandom_range(3)]);
		wait_for_results();
		repeat (8) send_page(pool[$urandom_range(3)]);
	endtask

	// bursts under random counts; most pages come from a pool a bit larger than
	// the frame set so hits, fills and evictions all happen, the rest are noise
	task automatic test_random_traffic(input int items);
		int                              sent;
		int                              burst;
		int                              active;
		int                              pool_n;
		int                              pick;
		logic [lpfr_pkg::COUNT_BITS-1:0] count;
		logic [lpfr_pkg::PAGE_BITS-1:0]  pool[$];
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(9);
			case (pick)
				0: count = 5'd0;
				1: count = 5'd1;
				2: count = 5'd16;
				3: count = lpfr_pkg::COUNT_BITS'($urandom_range(17, 31));
				default: count = lpfr_pkg::COUNT_BITS'($urandom_range(2, 15));
			endcase
			set_frame_count(count);
			active = (count > lpfr_pkg::FRAMES) ? lpfr_pkg::FRAMES : count;
			pool_n = active + $urandom_range(1, 4);
			pool.delete();
			repeat (pool_n) pool.insert(pool.size(), lpfr_pkg::PAGE_BITS'($urandom));
			burst = (count == 0) ? $urandom_range(4, 12) : $urandom_range(20, 60);
			for (int k = 0; k < burst && sent < items; k++) begin
				if ($urandom_range(99) < 85)
					send_page(pool[$urandom_range(pool.size() - 1)]);
				else
					send_page(lpfr_pkg::PAGE_BITS'($urandom));
				sent++;
			end
		end
	endtask

	// main sequence
	initial begin
		flush_shadow();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// light sender gaps, heavy receiver stalls
		send_idle_pct = 16;
		recv_idle_pct = 64;
		test_reset_default();
		test_small_lru();
		test_single_frame();
		test_zero_frames();
		test_saturated_count();
		test_random_traffic(270);
		test_pause_until_drained();

		// heavy sender gaps, light receiver stalls
		send_idle_pct = 64;
		recv_idle_pct = 16;
		test_random_traffic(270);

		// back to back
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(270);

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("lru_page_frame_replacement_test: done, clean");
		else
			$display("lru_page_frame_replacement_test: done, errors");
		$finish;
	end

	// hang guard
	initial begin
		#(RUN_LIMIT_NS);
		$display("lru_page_frame_replacement_test: done, errors");
		$finish;
	end

endmodule
